// File: design/bblc_pkg.sv
// Shared constants for the byte-budget LRU cache: operation kinds, result
// status codes, register indexes, stream widths and parameter defaults.
// No dependencies.
`default_nettype none

package bblc_pkg;

  // parameter defaults
  localparam int SLOTS_DEF    = 16;
  localparam int KEY_BITS_DEF = 32;

  // stream payload widths
  localparam int IN_TDATA_W  = 96;   // entry_key, entry_bytes, payload_handle
  localparam int IN_TUSER_W  = 3;    // kind
  localparam int OUT_TDATA_W = 136;  // out_key, out_handle, out_bytes, bytes_in_use, pad
  localparam int OUT_TUSER_W = 4;    // status
  localparam int USE_W       = 36;   // bytes_in_use field

  // configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_SIZE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SPILL    = 1'd1;

  // operation kinds
  localparam logic [IN_TUSER_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [IN_TUSER_W-1:0] KIND_GET    = 3'd1;
  localparam logic [IN_TUSER_W-1:0] KIND_REMOVE = 3'd2;
  localparam logic [IN_TUSER_W-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [IN_TUSER_W-1:0] KIND_TRIM   = 3'd4;

  // result status codes
  localparam logic [OUT_TUSER_W-1:0] ST_STORED    = 4'd0;
  localparam logic [OUT_TUSER_W-1:0] ST_UPDATED   = 4'd1;
  localparam logic [OUT_TUSER_W-1:0] ST_REJECTED  = 4'd2;
  localparam logic [OUT_TUSER_W-1:0] ST_HIT       = 4'd3;
  localparam logic [OUT_TUSER_W-1:0] ST_MISS      = 4'd4;
  localparam logic [OUT_TUSER_W-1:0] ST_REMOVED   = 4'd5;
  localparam logic [OUT_TUSER_W-1:0] ST_ABSENT    = 4'd6;
  localparam logic [OUT_TUSER_W-1:0] ST_CLEARED   = 4'd7;
  localparam logic [OUT_TUSER_W-1:0] ST_TRIMMED   = 4'd8;
  localparam logic [OUT_TUSER_W-1:0] ST_SPILLED   = 4'd9;
  localparam logic [OUT_TUSER_W-1:0] ST_DISCARDED = 4'd10;

endpackage

`default_nettype wire

// File: design/bblc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the cache entry store.
`default_nettype none

module bblc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: design/byte_budget_lru_cache.sv
// Byte-budget LRU cache: sequencer, slot recency table and result register.
// Depends on bblc_pkg and bblc_ram.
//
// Usage: one operation enters on the in_ stream (kind in in_tuser, key, size
// and handle in in_tdata); each produces one or more results on the out_
// stream, with out_tlast on the final one. Evictions come out as spilled or
// discarded results ahead of the closing result. Unknown kinds give none.
// Configuration (budget, spill mode) is to be written through cfg_we/cfg_addr/
// cfg_wdata while the block is idle; the block itself does not enforce this.
// Timing: in_tready is high only while idle; one operation is in work at a
// time. A key lookup walks the entry memory one slot per cycle, and each
// eviction of an add or trim needs another slot scan for the oldest entry.
// Clear and rejected adds skip the slot scan.
// Reset (synchronous, rst_n low) empties the cache, zeroes the budget and
// spill mode; no clearing pass is needed. A stalled receiver holds the
// current result in the output register and the sequencer waits before
// producing the next one.
`default_nettype none

module byte_budget_lru_cache #(
  parameter int SLOTS    = bblc_pkg::SLOTS_DEF,
  parameter int KEY_BITS = bblc_pkg::KEY_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [31:0] entry_key, [63:32] entry_bytes, [95:64] payload_handle
  input  wire logic [bblc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [2:0] kind
  input  wire logic [bblc_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [31:0] out_key, [63:32] out_handle, [95:64] out_bytes,
  // [131:96] bytes_in_use, [135:132] zero
  output logic      [bblc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [3:0] status
  output logic      [bblc_pkg::OUT_TUSER_W-1:0]   out_tuser,
  output logic                                    out_tlast,
  input  wire logic                               cfg_we,
  input  wire logic [bblc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [bblc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int UW = (32 + IW > bblc_pkg::USE_W) ? 32 + IW : bblc_pkg::USE_W;
  localparam int SW = UW + 1;
  localparam int DW = KEY_BITS + 64;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_SCAN      = 4'd2;
  localparam logic [3:0] S_UPD_A     = 4'd3;
  localparam logic [3:0] S_UPD_B     = 4'd4;
  localparam logic [3:0] S_REFRESH   = 4'd5;
  localparam logic [3:0] S_DROP      = 4'd6;
  localparam logic [3:0] S_EVICT_CHK = 4'd7;
  localparam logic [3:0] S_FULL_CHK  = 4'd8;
  localparam logic [3:0] S_FREE      = 4'd9;
  localparam logic [3:0] S_TRIM_CHK  = 4'd10;
  localparam logic [3:0] S_INSERT    = 4'd11;
  localparam logic [3:0] S_EMIT      = 4'd12;

  // scan modes
  localparam logic [1:0] SM_KEY  = 2'd0;
  localparam logic [1:0] SM_OLD  = 2'd1;
  localparam logic [1:0] SM_FREE = 2'd2;

  // eviction context
  localparam logic [1:0] CTX_BUDGET = 2'd0;
  localparam logic [1:0] CTX_FULL   = 2'd1;
  localparam logic [1:0] CTX_TRIM   = 2'd2;

  // recency table operations
  localparam logic [2:0] AOP_NOP     = 3'd0;
  localparam logic [2:0] AOP_REFRESH = 3'd1;
  localparam logic [2:0] AOP_DROP    = 3'd2;
  localparam logic [2:0] AOP_INSERT  = 3'd3;
  localparam logic [2:0] AOP_CLEAR   = 3'd4;

  logic [3:0]                       state_r, state_nxt;
  logic [3:0]                       ret_r, ret_nxt;
  logic [bblc_pkg::IN_TUSER_W-1:0]  kind_r, kind_nxt;
  logic [KEY_BITS-1:0]              key_r, key_nxt;
  logic [31:0]                      bytes_r, bytes_nxt;
  logic [31:0]                      handle_r, handle_nxt;
  logic [31:0]                      max_r, max_nxt;
  logic                             spill_r, spill_nxt;
  logic [UW-1:0]                    used_r, used_nxt;

  logic [SLOTS-1:0]                 valid_r, valid_nxt;
  logic [IW-1:0]                    age_r   [SLOTS];
  logic [IW-1:0]                    age_nxt [SLOTS];
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [2:0]                       age_op;

  logic [1:0]                       scan_mode_r, scan_mode_nxt;
  logic [IW-1:0]                    scan_addr_r, scan_addr_nxt;
  logic                             issue_r, issue_nxt;
  logic                             chk_v_r, chk_v_nxt;
  logic [IW-1:0]                    chk_idx_r, chk_idx_nxt;
  logic [1:0]                       ctx_r, ctx_nxt;
  logic                             start_scan;

  logic [IW-1:0]                    found_idx_r, found_idx_nxt;
  logic [IW-1:0]                    found_age_r, found_age_nxt;
  logic [31:0]                      found_key_r, found_key_nxt;
  logic [31:0]                      found_bytes_r, found_bytes_nxt;
  logic [31:0]                      found_handle_r, found_handle_nxt;

  logic [bblc_pkg::OUT_TUSER_W-1:0] res_status_r, res_status_nxt;
  logic [31:0]                      res_key_r, res_key_nxt;
  logic [31:0]                      res_handle_r, res_handle_nxt;
  logic [31:0]                      res_bytes_r, res_bytes_nxt;
  logic                             res_last_r, res_last_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [bblc_pkg::OUT_TUSER_W-1:0] out_status_r, out_status_nxt;
  logic [31:0]                      out_key_r, out_key_nxt;
  logic [31:0]                      out_handle_r, out_handle_nxt;
  logic [31:0]                      out_bytes_r, out_bytes_nxt;
  logic [bblc_pkg::USE_W-1:0]       out_use_r, out_use_nxt;
  logic                             out_last_r, out_last_nxt;

  logic                             ram_we;
  logic [DW-1:0]                    ram_wdata;
  logic [DW-1:0]                    ram_rdata;

  logic [63:0]                      in_key_wide;
  logic [63:0]                      key_wide;
  logic [63:0]                      rd_key_wide;
  logic [31:0]                      key32;
  logic [KEY_BITS-1:0]              rd_key;
  logic [31:0]                      rd_bytes;
  logic [31:0]                      rd_handle;
  logic                             chk_valid;
  logic [IW-1:0]                    chk_age;
  logic                             match;
  logic                             over_budget_add;

  bblc_ram #(
    .WIDTH (DW),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (found_idx_r),
    .wdata (ram_wdata),
    .raddr (scan_addr_r),
    .rdata (ram_rdata)
  );

  assign ram_wdata   = {handle_r, bytes_r, key_r};
  assign rd_key      = ram_rdata[KEY_BITS-1:0];
  assign rd_bytes    = ram_rdata[KEY_BITS+31:KEY_BITS];
  assign rd_handle   = ram_rdata[KEY_BITS+63:KEY_BITS+32];

  assign in_key_wide = 64'(in_tdata[31:0]);
  assign key_wide    = 64'(key_r);
  assign rd_key_wide = 64'(rd_key);
  assign key32       = key_wide[31:0];

  // shared compare stage of the slot scan
  assign chk_valid = valid_r[chk_idx_r];
  assign chk_age   = age_r[chk_idx_r];

  always_comb begin
    case (scan_mode_r)
      SM_KEY:  match = chk_valid && (rd_key == key_r);
      SM_OLD:  match = chk_valid && (CW'(chk_age) == cnt_r - CW'(1));
      SM_FREE: match = !chk_valid;
      default: match = 1'b0;
    endcase
  end

  assign over_budget_add = (SW'(used_r) + SW'(bytes_r)) > SW'(max_r);

  // recency ranks: 0 is newest, valid slots always hold a permutation
  always_comb begin
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    for (int i = 0; i < SLOTS; i++) begin
      age_nxt[i] = age_r[i];
    end
    case (age_op)
      AOP_REFRESH: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (IW'(i) == found_idx_r) begin
            age_nxt[i] = '0;
          end else if (valid_r[i] && age_r[i] < found_age_r) begin
            age_nxt[i] = age_r[i] + IW'(1);
          end
        end
      end
      AOP_DROP: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (IW'(i) == found_idx_r) begin
            age_nxt[i]   = '0;
            valid_nxt[i] = 1'b0;
          end else if (valid_r[i] && age_r[i] > found_age_r) begin
            age_nxt[i] = age_r[i] - IW'(1);
          end
        end
        cnt_nxt = cnt_r - CW'(1);
      end
      AOP_INSERT: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (IW'(i) == found_idx_r) begin
            age_nxt[i]   = '0;
            valid_nxt[i] = 1'b1;
          end else if (valid_r[i]) begin
            age_nxt[i] = age_r[i] + IW'(1);
          end
        end
        cnt_nxt = cnt_r + CW'(1);
      end
      AOP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          age_nxt[i] = '0;
        end
        valid_nxt = '0;
        cnt_nxt   = '0;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_comb begin
    state_nxt        = state_r;
    ret_nxt          = ret_r;
    kind_nxt         = kind_r;
    key_nxt          = key_r;
    bytes_nxt        = bytes_r;
    handle_nxt       = handle_r;
    max_nxt          = max_r;
    spill_nxt        = spill_r;
    used_nxt         = used_r;
    scan_mode_nxt    = scan_mode_r;
    scan_addr_nxt    = scan_addr_r;
    issue_nxt        = issue_r;
    chk_v_nxt        = 1'b0;
    chk_idx_nxt      = chk_idx_r;
    ctx_nxt          = ctx_r;
    start_scan       = 1'b0;
    found_idx_nxt    = found_idx_r;
    found_age_nxt    = found_age_r;
    found_key_nxt    = found_key_r;
    found_bytes_nxt  = found_bytes_r;
    found_handle_nxt = found_handle_r;
    res_status_nxt   = res_status_r;
    res_key_nxt      = res_key_r;
    res_handle_nxt   = res_handle_r;
    res_bytes_nxt    = res_bytes_r;
    res_last_nxt     = res_last_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_key_nxt      = out_key_r;
    out_handle_nxt   = out_handle_r;
    out_bytes_nxt    = out_bytes_r;
    out_use_nxt      = out_use_r;
    out_last_nxt     = out_last_r;
    age_op           = AOP_NOP;
    ram_we           = 1'b0;

    if (cfg_we) begin
      case (cfg_addr)
        bblc_pkg::REG_MAX_SIZE: max_nxt   = cfg_wdata;
        bblc_pkg::REG_SPILL:    spill_nxt = cfg_wdata[0];
        default:                max_nxt   = max_r;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt   = in_tuser;
          key_nxt    = in_key_wide[KEY_BITS-1:0];
          bytes_nxt  = in_tdata[63:32];
          handle_nxt = in_tdata[95:64];
          state_nxt  = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        ret_nxt = S_IDLE;
        case (kind_r)
          bblc_pkg::KIND_ADD: begin
            if (bytes_r > max_r) begin
              res_status_nxt = bblc_pkg::ST_REJECTED;
              res_key_nxt    = key32;
              res_handle_nxt = handle_r;
              res_bytes_nxt  = bytes_r;
              res_last_nxt   = 1'b1;
              state_nxt      = S_EMIT;
            end else begin
              scan_mode_nxt = SM_KEY;
              start_scan    = 1'b1;
            end
          end
          bblc_pkg::KIND_GET, bblc_pkg::KIND_REMOVE: begin
            scan_mode_nxt = SM_KEY;
            start_scan    = 1'b1;
          end
          bblc_pkg::KIND_CLEAR: begin
            age_op         = AOP_CLEAR;
            used_nxt       = '0;
            res_status_nxt = bblc_pkg::ST_CLEARED;
            res_key_nxt    = '0;
            res_handle_nxt = '0;
            res_bytes_nxt  = '0;
            res_last_nxt   = 1'b1;
            state_nxt      = S_EMIT;
          end
          bblc_pkg::KIND_TRIM: begin
            state_nxt = S_TRIM_CHK;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_SCAN: begin
        if (issue_r) begin
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = scan_addr_r;
          if (scan_addr_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            scan_addr_nxt = scan_addr_r + IW'(1);
          end
        end
        if (chk_v_r && (match || chk_idx_r == LAST_IDX)) begin
          found_idx_nxt    = chk_idx_r;
          found_age_nxt    = chk_age;
          found_key_nxt    = rd_key_wide[31:0];
          found_bytes_nxt  = rd_bytes;
          found_handle_nxt = rd_handle;
          ret_nxt          = S_IDLE;
          case (scan_mode_r)
            SM_KEY: begin
              res_key_nxt    = key32;
              res_handle_nxt = '0;
              res_bytes_nxt  = '0;
              res_last_nxt   = 1'b1;
              case (kind_r)
                bblc_pkg::KIND_ADD: begin
                  state_nxt = match ? S_UPD_A : S_EVICT_CHK;
                end
                bblc_pkg::KIND_GET: begin
                  res_status_nxt = bblc_pkg::ST_MISS;
                  state_nxt      = match ? S_REFRESH : S_EMIT;
                end
                bblc_pkg::KIND_REMOVE: begin
                  res_status_nxt = bblc_pkg::ST_ABSENT;
                  state_nxt      = match ? S_DROP : S_EMIT;
                end
                default: begin
                  state_nxt = S_IDLE;
                end
              endcase
            end
            SM_OLD:  state_nxt = match ? S_DROP : S_IDLE;
            SM_FREE: state_nxt = match ? S_INSERT : S_IDLE;
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_UPD_A: begin
        used_nxt  = used_r - UW'(found_bytes_r);
        ram_we    = 1'b1;
        age_op    = AOP_REFRESH;
        state_nxt = S_UPD_B;
      end

      S_UPD_B: begin
        used_nxt       = used_r + UW'(bytes_r);
        res_status_nxt = bblc_pkg::ST_UPDATED;
        res_key_nxt    = key32;
        res_handle_nxt = handle_r;
        res_bytes_nxt  = bytes_r;
        res_last_nxt   = 1'b1;
        ret_nxt        = S_IDLE;
        state_nxt      = S_EMIT;
      end

      S_REFRESH: begin
        age_op         = AOP_REFRESH;
        res_status_nxt = bblc_pkg::ST_HIT;
        res_key_nxt    = key32;
        res_handle_nxt = found_handle_r;
        res_bytes_nxt  = found_bytes_r;
        res_last_nxt   = 1'b1;
        ret_nxt        = S_IDLE;
        state_nxt      = S_EMIT;
      end

      S_DROP: begin
        age_op         = AOP_DROP;
        used_nxt       = used_r - UW'(found_bytes_r);
        res_handle_nxt = found_handle_r;
        res_bytes_nxt  = found_bytes_r;
        if (kind_r == bblc_pkg::KIND_REMOVE) begin
          res_status_nxt = bblc_pkg::ST_REMOVED;
          res_key_nxt    = key32;
          res_last_nxt   = 1'b1;
          ret_nxt        = S_IDLE;
        end else begin
          res_status_nxt = spill_r ? bblc_pkg::ST_SPILLED : bblc_pkg::ST_DISCARDED;
          res_key_nxt    = found_key_r;
          res_last_nxt   = 1'b0;
          case (ctx_r)
            CTX_BUDGET: ret_nxt = S_EVICT_CHK;
            CTX_FULL:   ret_nxt = S_FREE;
            CTX_TRIM:   ret_nxt = S_TRIM_CHK;
            default:    ret_nxt = S_IDLE;
          endcase
        end
        state_nxt = S_EMIT;
      end

      S_EVICT_CHK: begin
        if (cnt_r != '0 && over_budget_add) begin
          ctx_nxt       = CTX_BUDGET;
          scan_mode_nxt = SM_OLD;
          start_scan    = 1'b1;
        end else begin
          state_nxt = S_FULL_CHK;
        end
      end

      S_FULL_CHK: begin
        // no free slot left: evict the oldest entry; otherwise look for a free slot
        if (cnt_r == CW'(SLOTS)) begin
          ctx_nxt       = CTX_FULL;
          scan_mode_nxt = SM_OLD;
        end else begin
          scan_mode_nxt = SM_FREE;
        end
        start_scan = 1'b1;
      end

      S_FREE: begin
        scan_mode_nxt = SM_FREE;
        start_scan    = 1'b1;
      end

      S_TRIM_CHK: begin
        if (cnt_r != '0 && used_r > UW'(max_r)) begin
          ctx_nxt       = CTX_TRIM;
          scan_mode_nxt = SM_OLD;
          start_scan    = 1'b1;
        end else begin
          res_status_nxt = bblc_pkg::ST_TRIMMED;
          res_key_nxt    = '0;
          res_handle_nxt = '0;
          res_bytes_nxt  = '0;
          res_last_nxt   = 1'b1;
          ret_nxt        = S_IDLE;
          state_nxt      = S_EMIT;
        end
      end

      S_INSERT: begin
        age_op         = AOP_INSERT;
        ram_we         = 1'b1;
        used_nxt       = used_r + UW'(bytes_r);
        res_status_nxt = bblc_pkg::ST_STORED;
        res_key_nxt    = key32;
        res_handle_nxt = handle_r;
        res_bytes_nxt  = bytes_r;
        res_last_nxt   = 1'b1;
        ret_nxt        = S_IDLE;
        state_nxt      = S_EMIT;
      end

      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = res_key_r;
          out_handle_nxt = res_handle_r;
          out_bytes_nxt  = res_bytes_r;
          out_use_nxt    = used_r[bblc_pkg::USE_W-1:0];
          out_last_nxt   = res_last_r;
          state_nxt      = ret_r;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (start_scan) begin
      scan_addr_nxt = '0;
      issue_nxt     = 1'b1;
      chk_v_nxt     = 1'b0;
      state_nxt     = S_SCAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      max_r       <= '0;
      spill_r     <= 1'b0;
      used_r      <= '0;
      valid_r     <= '0;
      cnt_r       <= '0;
      issue_r     <= 1'b0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      max_r       <= max_nxt;
      spill_r     <= spill_nxt;
      used_r      <= used_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      issue_r     <= issue_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < SLOTS; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r         <= kind_nxt;
    key_r          <= key_nxt;
    bytes_r        <= bytes_nxt;
    handle_r       <= handle_nxt;
    scan_mode_r    <= scan_mode_nxt;
    scan_addr_r    <= scan_addr_nxt;
    chk_idx_r      <= chk_idx_nxt;
    ctx_r          <= ctx_nxt;
    found_idx_r    <= found_idx_nxt;
    found_age_r    <= found_age_nxt;
    found_key_r    <= found_key_nxt;
    found_bytes_r  <= found_bytes_nxt;
    found_handle_r <= found_handle_nxt;
    res_status_r   <= res_status_nxt;
    res_key_r      <= res_key_nxt;
    res_handle_r   <= res_handle_nxt;
    res_bytes_r    <= res_bytes_nxt;
    res_last_r     <= res_last_nxt;
    out_status_r   <= out_status_nxt;
    out_key_r      <= out_key_nxt;
    out_handle_r   <= out_handle_nxt;
    out_bytes_r    <= out_bytes_nxt;
    out_use_r      <= out_use_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0000, out_use_r, out_bytes_r, out_handle_r, out_key_r};

endmodule

`default_nettype wire

// File: design/bblc_checker.sv
// Port-level checks for the byte-budget LRU cache, bound to the top level.
// Depends on bblc_pkg.
`default_nettype none

module bblc_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [bblc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input wire logic [bblc_pkg::IN_TUSER_W-1:0]  in_tuser,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [bblc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [bblc_pkg::OUT_TUSER_W-1:0] out_tuser,
  input wire logic                             out_tlast,
  input wire logic                             cfg_we,
  input wire logic [bblc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input wire logic [bblc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result changed while stalled");

  // one operation at a time: busy right after an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after accepting an operation");

  // evictions never close an operation, every other result does
  a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == bblc_pkg::ST_SPILLED || out_tuser == bblc_pkg::ST_DISCARDED)
      |-> !out_tlast)
    else $error("eviction result marked last");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != bblc_pkg::ST_SPILLED && out_tuser != bblc_pkg::ST_DISCARDED
      |-> out_tlast)
    else $error("closing result without last");

  // clear leaves nothing held
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == bblc_pkg::ST_CLEARED |-> out_tdata[131:96] == '0)
    else $error("bytes in use not zero after clear");

endmodule

bind byte_budget_lru_cache bblc_checker u_bblc_checker (.*);

`default_nettype wire
